FILE: src/ptwa_pkg.sv
`default_nettype none

package ptwa_pkg;

    localparam int DEFAULT_TABLE_DEPTH = 64;
    localparam int ID_W                = 32;
    localparam int TIME_W              = 32;
    localparam int AGE_W               = 16;
    localparam int PEER_COUNT_W        = 7;
    localparam int CFG_DATA_W          = 32;

    localparam logic [ID_W-1:0]  OWN_ID_RESET  = '0;
    localparam logic [AGE_W-1:0] MAX_AGE_RESET = 16'd300;

    localparam logic OP_HEARD = 1'b0;
    localparam logic OP_PRUNE = 1'b1;

    localparam logic CFG_OWN_ID  = 1'b0;
    localparam logic CFG_MAX_AGE = 1'b1;

    typedef enum logic [2:0] {
        ST_REFRESHED = 3'd0,
        ST_ADDED     = 3'd1,
        ST_FULL      = 3'd2,
        ST_OWN       = 3'd3,
        ST_PRUNED    = 3'd4
    } status_t;

    typedef struct packed {
        logic              operation;
        logic [ID_W-1:0]   src_id;
        logic [TIME_W-1:0] now_seconds;
    } req_t;

    typedef struct packed {
        status_t                 status;
        logic [PEER_COUNT_W-1:0] peer_count;
    } rsp_t;

endpackage

`default_nettype wire

FILE: src/peer_table_with_aging.sv
`default_nettype none

// Peer table with aging.
// Command channel: a beat on req is taken at a clock edge where start is high
// and busy is low. Every beat yields one beat on rsp, marked by done for one
// cycle; the receiver cannot stall and must take it then.
// Configuration: cfg_we writes cfg_data to register cfg_index (0 own_id,
// 1 max_age) at the clock edge; only write while busy is low.
// Sequencing of a beat:
//   heard from own ID: answered from idle, busy stays low.
//   heard, other ID:   one table read per cycle from entry 0, compare in the
//                      cycle after the read; refresh on match, else add/full.
//   prune:             entries read last first; a stale one gets the last entry.
// The table sits in two single-port-read RAMs (IDs, times) with registered
// read data; the sequencer does one read-compare-write at a time.
// busy drops in the cycle done is high, so the next beat can start then.
// Reset clears the count (table empty), own_id to 0 and max_age to 300;
// the RAM contents need no clearing.

module peer_table_with_aging
    import ptwa_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire req_t                  req,
    output logic                       done,
    output rsp_t                       rsp,
    input  wire logic                  cfg_we,
    input  wire logic                  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

    typedef enum logic [4:0] {
        S_IDLE     = 5'b00001,
        S_HEARD    = 5'b00010,
        S_PR_ISSUE = 5'b00100,
        S_PR_CHECK = 5'b01000,
        S_PR_MOVE  = 5'b10000
    } state_t;

    state_t            state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [CW-1:0]     idx_reg, idx_next;
    logic [AW-1:0]     pidx_reg, pidx_next;
    logic              pend_reg, pend_next;
    req_t              item_reg, item_next;
    logic [ID_W-1:0]   own_id_reg;
    logic [AGE_W-1:0]  max_age_reg;
    logic              done_reg, done_next;
    rsp_t              rsp_reg, rsp_next;

    logic [ID_W-1:0]   ids_mem   [TABLE_DEPTH];
    logic [TIME_W-1:0] times_mem [TABLE_DEPTH];
    logic [ID_W-1:0]   id_q;
    logic [TIME_W-1:0] time_q;

    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic              id_we;
    logic              time_we;
    logic [AW-1:0]     wr_addr;

    logic [CW-1:0]     idx_dec;
    logic [CW-1:0]     last;
    logic [TIME_W-1:0] age;

    assign idx_dec = idx_reg - 1'b1;
    assign last    = count_reg - 1'b1;
    assign age     = item_reg.now_seconds - time_q;

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            id_q   <= ids_mem[rd_addr];
            time_q <= times_mem[rd_addr];
        end
        if (id_we)
        begin
            ids_mem[wr_addr] <= (state_reg == S_PR_MOVE) ? id_q : item_reg.src_id;
        end
        if (time_we)
        begin
            times_mem[wr_addr] <= (state_reg == S_PR_MOVE) ? time_q : item_reg.now_seconds;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        pidx_next  = pidx_reg;
        pend_next  = pend_reg;
        item_next  = item_reg;
        done_next  = 1'b0;
        rsp_next   = rsp_reg;
        rd_en      = 1'b0;
        rd_addr    = idx_reg[AW-1:0];
        id_we      = 1'b0;
        time_we    = 1'b0;
        wr_addr    = pidx_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    item_next = req;
                    if (req.operation == OP_PRUNE)
                    begin
                        idx_next   = count_reg;
                        state_next = S_PR_ISSUE;
                    end
                    else if (req.src_id == own_id_reg)
                    begin
                        done_next         = 1'b1;
                        rsp_next.status   = ST_OWN;
                        rsp_next.peer_count = PEER_COUNT_W'(count_reg);
                    end
                    else
                    begin
                        idx_next   = '0;
                        pend_next  = 1'b0;
                        state_next = S_HEARD;
                    end
                end
            end
            S_HEARD:
            begin
                if (pend_reg && id_q == item_reg.src_id)
                begin
                    time_we    = 1'b1;
                    wr_addr    = pidx_reg;
                    done_next  = 1'b1;
                    rsp_next.status     = ST_REFRESHED;
                    rsp_next.peer_count = PEER_COUNT_W'(count_reg);
                    state_next = S_IDLE;
                end
                else if (idx_reg == count_reg)
                begin
                    done_next = 1'b1;
                    if (count_reg < DEPTH_C)
                    begin
                        id_we      = 1'b1;
                        time_we    = 1'b1;
                        wr_addr    = count_reg[AW-1:0];
                        count_next = count_reg + 1'b1;
                        rsp_next.status = ST_ADDED;
                    end
                    else
                    begin
                        rsp_next.status = ST_FULL;
                    end
                    rsp_next.peer_count = PEER_COUNT_W'(count_next);
                    state_next = S_IDLE;
                end
                else
                begin
                    rd_en     = 1'b1;
                    rd_addr   = idx_reg[AW-1:0];
                    pend_next = 1'b1;
                    pidx_next = idx_reg[AW-1:0];
                    idx_next  = idx_reg + 1'b1;
                end
            end
            S_PR_ISSUE:
            begin
                if (idx_reg == '0)
                begin
                    done_next  = 1'b1;
                    rsp_next.status     = ST_PRUNED;
                    rsp_next.peer_count = PEER_COUNT_W'(count_reg);
                    state_next = S_IDLE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = idx_dec[AW-1:0];
                    state_next = S_PR_CHECK;
                end
            end
            S_PR_CHECK:
            begin
                if (age > TIME_W'(max_age_reg))
                begin
                    rd_en      = 1'b1;
                    rd_addr    = last[AW-1:0];
                    state_next = S_PR_MOVE;
                end
                else
                begin
                    idx_next   = idx_dec;
                    state_next = S_PR_ISSUE;
                end
            end
            S_PR_MOVE:
            begin
                id_we      = 1'b1;
                time_we    = 1'b1;
                wr_addr    = idx_dec[AW-1:0];
                count_next = last;
                idx_next   = idx_dec;
                state_next = S_PR_ISSUE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            pend_reg    <= 1'b0;
            done_reg    <= 1'b0;
            own_id_reg  <= OWN_ID_RESET;
            max_age_reg <= MAX_AGE_RESET;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
            done_reg  <= done_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_OWN_ID:  own_id_reg  <= cfg_data[ID_W-1:0];
                    CFG_MAX_AGE: max_age_reg <= cfg_data[AGE_W-1:0];
                    default:     ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        pidx_reg <= pidx_next;
        item_reg <= item_next;
        rsp_reg  <= rsp_next;
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

    // checks

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_C)
        else $error("peer count above table depth");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> state_reg == S_IDLE)
        else $error("result beat while sequencer busy");

    a_added_grows: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && rsp_reg.status == ST_ADDED |->
            count_reg == CW'($past(count_reg) + 1'b1))
        else $error("add did not grow count by one");

    a_keep_count: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && (rsp_reg.status == ST_REFRESHED || rsp_reg.status == ST_FULL ||
            rsp_reg.status == ST_OWN) |-> $stable(count_reg))
        else $error("count changed on refresh, full or own beat");

    a_prune_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        $past(state_reg) == S_PR_MOVE |-> count_reg == CW'($past(count_reg) - 1'b1))
        else $error("prune move did not drop count by one");

endmodule

`default_nettype wire
